// File: design/tcp_ack_congestion_control_top_macros.svh
// assertion macros for the tcp ack engine checker
`ifndef TCP_ACK_CONGESTION_CONTROL_TOP_MACROS_SVH
`define TCP_ACK_CONGESTION_CONTROL_TOP_MACROS_SVH
// implication checked on every edge outside reset
`define TAC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tac check failed");
// next-cycle implication checked outside reset
`define TAC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tac check failed");
`endif

// File: design/tac_pkg.sv
// shared types and codes for the tcp ack engine
`default_nettype none
package tac_pkg;
  localparam logic [1:0] MODE_OPEN = 2'd0;
  localparam logic [1:0] MODE_SENT = 2'd1;
  localparam logic [1:0] MODE_ACK  = 2'd2;

  localparam logic [3:0] ST_OPENED = 4'd0;
  localparam logic [3:0] ST_SENT   = 4'd1;
  localparam logic [3:0] ST_RFULL  = 4'd2;
  localparam logic [3:0] ST_FULL   = 4'd3;
  localparam logic [3:0] ST_PART   = 4'd4;
  localparam logic [3:0] ST_DUP    = 4'd5;
  localparam logic [3:0] ST_FRTX   = 4'd6;
  localparam logic [3:0] ST_UNK    = 4'd7;
  localparam logic [3:0] ST_OOW    = 4'd8;

  localparam logic [1:0] PH_SLOW  = 2'd0;
  localparam logic [1:0] PH_AVOID = 2'd1;
  localparam logic [1:0] PH_RECOV = 2'd2;

  localparam logic [1:0] TMR_NONE  = 2'd0;
  localparam logic [1:0] TMR_START = 2'd1;
  localparam logic [1:0] TMR_STOP  = 2'd2;

  localparam logic [2:0] REG_MSS  = 3'd0;
  localparam logic [2:0] REG_PMW  = 3'd1;
  localparam logic [2:0] REG_DEFT = 3'd2;
  localparam logic [2:0] REG_MINT = 3'd3;
  localparam logic [2:0] REG_MAXT = 3'd4;

  localparam int FxW = 24;
endpackage
`default_nettype wire

// File: design/tac_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module tac_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/tcp_ack_congestion_control_top.sv
// tcp sender ack engine: reno congestion window and rtt timeout estimate
//
// input channel in_valid/in_ready carries one event (open, sent, ack);
// output channel out_valid/out_ready returns exactly one result beat per
// event. configuration is a plain write port (cfg_we, cfg_index, cfg_data)
// written while idle.
// one event at a time: the block is not ready while an event is in work.
// open, send, duplicate and out-of-window acks go from decode straight to
// the output register; fast retransmit outside recovery passes the window
// multiply state, a full or partial ack passes release and growth, a
// partial or unmatched ack walks the segment ring one entry per cycle
// through the ram read port, avoidance growth runs a 32-step restoring
// divider and an rtt update passes through the estimator states.
// the result sits in an output register; a stalled receiver holds it, and
// the next event is taken the cycle after the result is accepted.
// reset (synchronous, active high) loads register defaults and empties the
// ring; ring contents are undefined until written and need no clearing.
`default_nettype none
module tcp_ack_congestion_control_top #(
  parameter int RING_DEPTH    = 16,
  parameter int RTT_FRAC_BITS = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [31:0] seq_or_ack,
  input  wire logic [15:0] seg_bytes,
  input  wire logic [15:0] peer_window,
  input  wire logic [31:0] now_ms,
  input  wire logic        time_this,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       ack_status,
  output logic [31:0]      cwnd_bytes,
  output logic [31:0]      slow_start_threshold,
  output logic [1:0]       cong_phase,
  output logic [15:0]      send_window,
  output logic [1:0]       timer_cmd,
  output logic [15:0]      timeout_ms,
  output logic [4:0]       released_count
);
  import tac_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int FW = FxW;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_SRCH  = 4'd2;
  localparam logic [3:0] S_REL   = 4'd3;
  localparam logic [3:0] S_RTT0  = 4'd4;
  localparam logic [3:0] S_RTT1  = 4'd5;
  localparam logic [3:0] S_RTT2  = 4'd6;
  localparam logic [3:0] S_RTT3  = 4'd7;
  localparam logic [3:0] S_GROW  = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;
  localparam logic [3:0] S_MUL   = 4'd12;

  logic [3:0]  state;
  logic [15:0] r_mss, r_deft, r_mint, r_maxt;
  logic [31:0] r_pmw;

  logic [1:0]  i_mode;
  logic [31:0] i_sa, i_now;
  logic [15:0] i_len, i_pw;
  logic        i_tt;

  logic [31:0] oldest_unacked, next_send_end, cwnd, ssthresh, timed_end, timed_stamp;
  logic [1:0]  dup_count, phase;
  logic [AW-1:0] ring_head;
  logic [CW-1:0] ring_count;
  logic        timing_active, first_sample;
  logic [FW-1:0] rtt_estimate, rtt_deviation, samp;
  logic [15:0] cur_timeout, send_win;

  logic [CW-1:0] idx;
  logic [5:0]  div_cnt;
  logic [31:0] quo, dvd;
  logic [31:0] rem;
  logic [FW-1:0] acc;
  logic [3:0]  st_r;
  logic [1:0]  tcmd_r;
  logic [CW-1:0] rel_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_rdata;

  tac_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_ring (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(i_sa),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  logic [CW:0] wsum, rsum, hsum;
  logic [31:0] rel_off, win_off, rtt_raw, cwnd_sat;
  logic [32:0] ssum;
  logic [32:0] trial;
  logic [FW+4:0] to_full;

  // ring positions wrap by one compare and subtract
  assign wsum = (CW+1)'(ring_head) + (CW+1)'(ring_count);
  assign rsum = (CW+1)'(ring_head) + (CW+1)'(idx);
  assign hsum = (CW+1)'(ring_head) + (CW+1)'(rel_r);
  assign ram_we = (state == S_DEC) && (i_mode == MODE_SENT) &&
                  (ring_count < CW'(RING_DEPTH));
  assign ram_waddr = (wsum >= (CW+1)'(RING_DEPTH)) ? AW'(wsum - (CW+1)'(RING_DEPTH)) :
                                                     AW'(wsum);
  assign ram_raddr = (rsum >= (CW+1)'(RING_DEPTH)) ? AW'(rsum - (CW+1)'(RING_DEPTH)) :
                                                     AW'(rsum);
  assign rel_off = i_sa - oldest_unacked;
  assign win_off = next_send_end - oldest_unacked;
  assign rtt_raw = i_now - timed_stamp;
  assign trial = {rem, dvd[31]} - {1'b0, cwnd};
  assign in_ready = (state == S_IDLE);

  // shared saturating window adder
  always_comb begin
    case (state)
      S_MUL:   ssum = {1'b0, ssthresh} + {15'd0, r_mss, 1'b0} + {17'd0, r_mss};
      S_DIV:   ssum = {1'b0, cwnd} + {1'b0, quo};
      default: ssum = {1'b0, cwnd} + {17'd0, r_mss};
    endcase
  end
  assign cwnd_sat = ssum[32] ? 32'hFFFF_FFFF : ssum[31:0];
  assign to_full = ({5'd0, rtt_estimate} + {3'd0, rtt_deviation, 2'd0}) >> RTT_FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      r_mss <= 16'd1460; r_pmw <= 32'd65535; r_deft <= 16'd1000;
      r_mint <= 16'd200; r_maxt <= 16'd60000;
      oldest_unacked <= '0; next_send_end <= '0; dup_count <= '0;
      phase <= PH_SLOW; cwnd <= '0; ssthresh <= '0; ring_head <= '0;
      ring_count <= '0; timing_active <= 1'b0; timed_end <= '0;
      timed_stamp <= '0; first_sample <= 1'b1; rtt_estimate <= '0;
      rtt_deviation <= '0; cur_timeout <= 16'd1000; send_win <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MSS:  r_mss <= cfg_data[15:0];
          REG_PMW:  r_pmw <= cfg_data;
          REG_DEFT: r_deft <= cfg_data[15:0];
          REG_MINT: r_mint <= cfg_data[15:0];
          REG_MAXT: r_maxt <= cfg_data[15:0];
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            i_mode <= mode; i_sa <= seq_or_ack; i_len <= seg_bytes;
            i_pw <= peer_window; i_now <= now_ms; i_tt <= time_this;
            st_r <= ST_UNK; tcmd_r <= TMR_NONE; rel_r <= '0;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          state <= S_DONE;
          case (i_mode)
            MODE_OPEN: begin
              oldest_unacked <= i_sa; next_send_end <= i_sa; dup_count <= '0;
              send_win <= i_pw; ring_head <= '0; ring_count <= '0;
              timing_active <= 1'b0; cur_timeout <= r_deft; phase <= PH_SLOW;
              cwnd <= {16'd0, r_mss}; ssthresh <= {1'b0, r_pmw[31:1]};
              tcmd_r <= TMR_STOP; st_r <= ST_OPENED;
            end
            MODE_SENT: begin
              if (ring_count >= CW'(RING_DEPTH)) st_r <= ST_RFULL;
              else begin
                ring_count <= ring_count + 1'b1;
                next_send_end <= i_sa + {16'd0, i_len};
                if (i_tt && !timing_active) begin
                  timing_active <= 1'b1; timed_end <= i_sa + {16'd0, i_len};
                  timed_stamp <= i_now;
                end
                st_r <= ST_SENT;
              end
            end
            MODE_ACK: begin
              if (rel_off > win_off) st_r <= ST_OOW;
              else if (i_sa == oldest_unacked) begin
                send_win <= i_pw;
                if (dup_count == 2'd2) begin
                  dup_count <= '0; st_r <= ST_FRTX; timing_active <= 1'b0;
                  tcmd_r <= TMR_START;
                  if (phase != PH_RECOV) begin
                    phase <= PH_RECOV;
                    ssthresh <= ({1'b0, cwnd[31:1]} < {16'd0, r_mss}) ?
                                {16'd0, r_mss} : {1'b0, cwnd[31:1]};
                    state <= S_MUL;
                  end
                end else begin
                  dup_count <= dup_count + 1'b1; st_r <= ST_DUP;
                end
              end else if (i_sa == next_send_end) begin
                rel_r <= ring_count; state <= S_REL;
              end else begin
                idx <= '0; state <= S_SRCH;
              end
            end
            default: ;
          endcase
        end
        S_MUL: begin
          cwnd <= cwnd_sat;
          state <= S_DONE;
        end
        S_SRCH: begin
          // registered read: ram_rdata holds the entry at idx-1
          if (idx != '0 && ram_rdata == i_sa) begin
            rel_r <= idx - 1'b1; state <= S_REL;
          end else if (idx >= ring_count) state <= S_DONE;
          else idx <= idx + 1'b1;
        end
        S_REL: begin
          ring_head <= (hsum >= (CW+1)'(RING_DEPTH)) ? AW'(hsum - (CW+1)'(RING_DEPTH)) :
                                                       AW'(hsum);
          ring_count <= ring_count - rel_r;
          oldest_unacked <= i_sa; send_win <= i_pw; dup_count <= '0;
          tcmd_r <= (i_sa == next_send_end) ? TMR_STOP : TMR_START;
          st_r <= (i_sa == next_send_end) ? ST_FULL : ST_PART;
          if (timing_active && i_sa == timed_end) begin
            timing_active <= 1'b0;
            samp <= (|(rtt_raw >> (FW - RTT_FRAC_BITS))) ? {FW{1'b1}} :
                    FW'(rtt_raw << RTT_FRAC_BITS);
            state <= S_RTT0;
          end else state <= S_GROW;
        end
        S_RTT0: begin
          if (first_sample) begin
            first_sample <= 1'b0;
            rtt_estimate <= samp; rtt_deviation <= samp >> 1;
            state <= S_RTT2;
          end else begin
            acc <= FW'(({4'd0, rtt_estimate} * 28'd7 + {4'd0, samp}) >> 3);
            state <= S_RTT1;
          end
        end
        S_RTT1: begin
          rtt_estimate <= acc;
          acc <= FW'((({4'd0, rtt_deviation} * 28'd3) +
                      ((samp > acc) ? {4'd0, samp - acc} : {4'd0, acc - samp})) >> 2);
          state <= S_RTT3;
        end
        S_RTT3: begin
          rtt_deviation <= acc;
          state <= S_RTT2;
        end
        S_RTT2: begin
          if (to_full < {13'd0, r_mint}) cur_timeout <= r_mint;
          else if (to_full > {13'd0, r_maxt}) cur_timeout <= r_maxt;
          else cur_timeout <= to_full[15:0];
          state <= S_GROW;
        end
        S_GROW: begin
          state <= S_DONE;
          if (phase == PH_SLOW) begin
            cwnd <= cwnd_sat;
            if (cwnd_sat >= ssthresh) phase <= PH_AVOID;
          end else if (phase == PH_AVOID) begin
            if (cwnd == '0) cwnd <= {16'd0, r_mss};
            else begin
              dvd <= {16'd0, r_mss} * {16'd0, r_mss}; rem <= '0; quo <= '0;
              div_cnt <= '0;
              state <= S_DIV;
            end
          end else begin
            phase <= PH_AVOID; cwnd <= ssthresh;
          end
        end
        S_DIV: begin
          if (div_cnt == 6'd32) begin
            cwnd <= cwnd_sat;
            state <= S_DONE;
          end else begin
            if (!trial[32]) begin
              rem <= trial[31:0]; quo <= {quo[30:0], 1'b1};
            end else begin
              rem <= {rem[30:0], dvd[31]}; quo <= {quo[30:0], 1'b0};
            end
            dvd <= {dvd[30:0], 1'b0};
            div_cnt <= div_cnt + 1'b1;
          end
        end
        S_DONE: begin
          ack_status <= st_r; cwnd_bytes <= cwnd; slow_start_threshold <= ssthresh;
          cong_phase <= phase; send_window <= send_win; timer_cmd <= tcmd_r;
          timeout_ms <= cur_timeout; released_count <= 5'(rel_r);
          out_valid <= 1'b1; state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: design/tac_checker.sv
// port-level checks for the tcp ack engine
`default_nettype none
`include "tcp_ack_congestion_control_top_macros.svh"
module tac_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] ack_status,
  input wire logic [1:0] cong_phase,
  input wire logic [1:0] timer_cmd
);
  import tac_pkg::*;
  `TAC_ASSERT_IMP(a_no_overlap, clk, rst, out_valid, !in_ready)
  `TAC_ASSERT_NXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(ack_status))
  `TAC_ASSERT_NXT(a_busy_after_take, clk, rst, in_valid && in_ready, !in_ready)
  `TAC_ASSERT_IMP(a_open_stops, clk, rst, out_valid && ack_status == ST_OPENED,
                  timer_cmd == TMR_STOP && cong_phase == PH_SLOW)
endmodule

bind tcp_ack_congestion_control_top tac_checker u_tac_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .ack_status(ack_status),
  .cong_phase(cong_phase), .timer_cmd(timer_cmd)
);
`default_nettype wire

// File: verif/tcp_ack_congestion_control_top_tb.sv
// self-checking testbench for the tcp ack engine: directed and random event streams
`default_nettype none
module tcp_ack_congestion_control_top_tb;
  import tac_pkg::*;

  // mode code with no meaning in the block
  localparam logic [1:0] MODE_NONE = 2'd3;

  typedef struct packed {
    logic [3:0]  status;
    logic [31:0] cwnd;
    logic [31:0] ssthresh;
    logic [1:0]  phase;
    logic [15:0] swin;
    logic [1:0]  tcmd;
    logic [15:0] tmo;
    logic [4:0]  released;
  } ack_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] mode = '0;
  logic [31:0] seq_or_ack = '0;
  logic [15:0] seg_bytes = '0;
  logic [15:0] peer_window = '0;
  logic [31:0] now_ms = '0;
  logic time_this = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] ack_status;
  logic [31:0] cwnd_bytes, slow_start_threshold;
  logic [1:0] cong_phase, timer_cmd;
  logic [15:0] send_window, timeout_ms;
  logic [4:0] released_count;

  tcp_ack_congestion_control_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .mode(mode), .seq_or_ack(seq_or_ack),
    .seg_bytes(seg_bytes), .peer_window(peer_window), .now_ms(now_ms),
    .time_this(time_this), .out_valid(out_valid), .out_ready(out_ready),
    .ack_status(ack_status), .cwnd_bytes(cwnd_bytes),
    .slow_start_threshold(slow_start_threshold), .cong_phase(cong_phase),
    .send_window(send_window), .timer_cmd(timer_cmd), .timeout_ms(timeout_ms),
    .released_count(released_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [31:0] m_mss, m_pmw, m_deft, m_mint, m_maxt;
  logic [31:0] m_una, m_nxt, m_cwnd, m_ssth, m_tend, m_tstamp;
  logic [1:0]  m_dup, m_phase;
  logic [31:0] m_ring [16];
  logic [3:0]  m_head;
  logic [4:0]  m_count;
  logic        m_timing, m_first;
  logic [23:0] m_est, m_dev;
  logic [15:0] m_tmo, m_swin;

  ack_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int events_sent = 0;
  int status_hits[9];

  // tracking for well-formed streams
  logic [31:0] tb_seq;
  logic [31:0] tb_now;
  logic [31:0] tb_starts[$];

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic model_reset();
    m_mss = 1460; m_pmw = 65535; m_deft = 1000; m_mint = 200; m_maxt = 60000;
    m_una = 0; m_nxt = 0; m_dup = 0; m_phase = PH_SLOW; m_cwnd = 0; m_ssth = 0;
    m_head = 0; m_count = 0; m_timing = 0; m_tend = 0; m_tstamp = 0;
    m_first = 1; m_est = 0; m_dev = 0; m_tmo = 1000; m_swin = 0;
  endtask

  task automatic rtt_sample(logic [31:0] now);
    logic [63:0] s, est, dev, diff, to;
    s = {32'd0, now - m_tstamp} << 3;
    if (s > 64'hFF_FFFF) s = 64'hFF_FFFF;
    m_timing = 0;
    if (m_first) begin
      m_first = 0;
      est = s;
      dev = s >> 1;
    end else begin
      est = (7 * {40'd0, m_est} + s) >> 3;
      diff = (s > est) ? s - est : est - s;
      dev = (3 * {40'd0, m_dev} + diff) >> 2;
    end
    m_est = est[23:0];
    m_dev = dev[23:0];
    to = ({40'd0, m_est} + 4 * {40'd0, m_dev}) >> 3;
    if (to < {32'd0, m_mint}) to = {32'd0, m_mint};
    else if (to > {32'd0, m_maxt}) to = {32'd0, m_maxt};
    m_tmo = to[15:0];
  endtask

  task automatic grow_cwnd();
    logic [31:0] sq;
    if (m_phase == PH_SLOW) begin
      m_cwnd = sat_add(m_cwnd, m_mss);
      if (m_cwnd >= m_ssth) m_phase = PH_AVOID;
    end else if (m_phase == PH_AVOID) begin
      sq = m_mss * m_mss;
      m_cwnd = sat_add(m_cwnd, m_cwnd == 0 ? m_mss : sq / m_cwnd);
    end else begin
      m_phase = PH_AVOID;
      m_cwnd = m_ssth;
    end
  endtask

  task automatic predict_event(logic [1:0] md, logic [31:0] sa, logic [15:0] len,
                               logic [15:0] pw, logic [31:0] now, logic tt);
    ack_result_t r;
    logic [3:0] st;
    logic [1:0] tc;
    logic [4:0] rel, k;
    logic full, found;
    st = ST_UNK; tc = TMR_NONE; rel = 0;
    if (md == MODE_OPEN) begin
      m_una = sa; m_nxt = sa; m_dup = 0; m_swin = pw; m_head = 0; m_count = 0;
      m_timing = 0; m_tmo = m_deft[15:0]; m_phase = PH_SLOW; m_cwnd = m_mss;
      m_ssth = m_pmw >> 1; tc = TMR_STOP; st = ST_OPENED;
    end else if (md == MODE_SENT) begin
      if (m_count >= 16) st = ST_RFULL;
      else begin
        m_ring[4'(m_head + m_count[3:0])] = sa;
        m_count++;
        m_nxt = sa + len;
        if (tt && !m_timing) begin
          m_timing = 1; m_tend = sa + len; m_tstamp = now;
        end
        st = ST_SENT;
      end
    end else if (md == MODE_ACK) begin
      if ((sa - m_una) > (m_nxt - m_una)) st = ST_OOW;
      else if (sa == m_una) begin
        m_swin = pw;
        m_dup = m_dup + 1;
        st = ST_DUP;
        if (m_dup == 3) begin
          m_dup = 0; st = ST_FRTX; m_timing = 0; tc = TMR_START;
          if (m_phase != PH_RECOV) begin
            m_phase = PH_RECOV;
            m_ssth = m_cwnd >> 1;
            if (m_ssth < m_mss) m_ssth = m_mss;
            m_cwnd = sat_add(m_ssth, 3 * m_mss);
          end
        end
      end else begin
        full = (sa == m_nxt);
        found = full;
        k = m_count;
        if (!full) begin
          for (int i = 0; i < m_count; i++) begin
            if (!found && m_ring[4'(m_head + i)] == sa) begin
              k = 5'(i); found = 1;
            end
          end
        end
        if (found) begin
          rel = k;
          m_head = 4'(m_head + k[3:0]);
          m_count = m_count - k;
          m_una = sa; m_swin = pw; m_dup = 0;
          if (m_timing && sa == m_tend) rtt_sample(now);
          tc = full ? TMR_STOP : TMR_START;
          st = full ? ST_FULL : ST_PART;
          grow_cwnd();
        end
      end
    end
    r.status = st; r.cwnd = m_cwnd; r.ssthresh = m_ssth; r.phase = m_phase;
    r.swin = m_swin; r.tcmd = tc; r.tmo = m_tmo; r.released = rel;
    expected_results.push_back(r);
    if (st <= ST_OOW) status_hits[st]++;
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on result %0d: %s got %0h expected %0h", results_seen, what, got,
             want);
    errors++;
  endtask

  // result checker with random backpressure
  initial begin
    ack_result_t e;
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = $urandom_range(0, 4);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat, ack_status", 32'(ack_status), 32'(ST_UNK));
      end else begin
        e = expected_results.pop_front();
        if (ack_status !== e.status) report_mismatch("ack_status", 32'(ack_status), 32'(e.status));
        if (cwnd_bytes !== e.cwnd) report_mismatch("cwnd_bytes", cwnd_bytes, e.cwnd);
        if (slow_start_threshold !== e.ssthresh)
          report_mismatch("slow_start_threshold", slow_start_threshold, e.ssthresh);
        if (cong_phase !== e.phase) report_mismatch("cong_phase", 32'(cong_phase), 32'(e.phase));
        if (send_window !== e.swin) report_mismatch("send_window", 32'(send_window), 32'(e.swin));
        if (timer_cmd !== e.tcmd) report_mismatch("timer_cmd", 32'(timer_cmd), 32'(e.tcmd));
        if (timeout_ms !== e.tmo) report_mismatch("timeout_ms", 32'(timeout_ms), 32'(e.tmo));
        if (released_count !== e.released)
          report_mismatch("released_count", 32'(released_count), 32'(e.released));
      end
      results_seen++;
    end
  end

  // valid stays high after a beat until the next gap or drain lowers it
  task automatic send_event(logic [1:0] md, logic [31:0] sa, logic [15:0] len,
                            logic [15:0] pw, logic [31:0] now, logic tt);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; mode <= md; seq_or_ack <= sa; seg_bytes <= len;
    peer_window <= pw; now_ms <= now; time_this <= tt;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_event(md, sa, len, pw, now, tt);
    events_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_MSS:  m_mss = {16'd0, val[15:0]};
      REG_PMW:  m_pmw = val;
      REG_DEFT: m_deft = {16'd0, val[15:0]};
      REG_MINT: m_mint = {16'd0, val[15:0]};
      REG_MAXT: m_maxt = {16'd0, val[15:0]};
      default: ;
    endcase
  endtask

  task automatic open_conn(logic [31:0] seq);
    tb_seq = seq;
    tb_starts.delete();
    send_event(MODE_OPEN, seq, 16'($urandom), 16'($urandom), tb_now, 1'($urandom));
  endtask

  task automatic send_segment(logic [15:0] len, logic tt);
    tb_now += $urandom_range(0, 50);
    if (tb_starts.size() < 16) tb_starts.push_back(tb_seq);
    send_event(MODE_SENT, tb_seq, len, 16'($urandom), tb_now, tt);
    tb_seq += len;
  endtask

  task automatic recv_ack(logic [31:0] a);
    tb_now += $urandom_range(0, 3000);
    send_event(MODE_ACK, a, 16'($urandom), 16'($urandom), tb_now, 1'($urandom));
  endtask

  task automatic test_directed();
    open_conn(32'hFFFF_FFF0);
    send_segment(16'hFFFF, 1);
    send_segment(16'd0, 1);
    send_segment(16'd100, 0);
    recv_ack(tb_seq + 5);
    recv_ack(32'hFFFF_FFF0);
    recv_ack(32'hFFFF_FFF0);
    recv_ack(32'hFFFF_FFF0);
    recv_ack(32'hFFFF_FFF0);
    recv_ack(32'hFFFF_FFF0);
    recv_ack(32'hFFFF_FFF0);
    recv_ack(tb_starts[1] + 1);
    recv_ack(tb_starts[2]);
    recv_ack(tb_seq);
    recv_ack(tb_seq);
    send_event(MODE_NONE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 1);
    for (int i = 0; i < 17; i++) send_segment(16'd10, 1);
  endtask

  task automatic test_config(int setting);
    drain();
    case (setting)
      0: begin
        write_reg(REG_MSS, 32'd1); write_reg(REG_PMW, 32'd0);
        write_reg(REG_DEFT, 32'd1); write_reg(REG_MINT, 32'd1);
        write_reg(REG_MAXT, 32'd1);
      end
      1: begin
        write_reg(REG_MSS, 32'hFFFF); write_reg(REG_PMW, 32'hFFFF_FFFF);
        write_reg(REG_DEFT, 32'hFFFF); write_reg(REG_MINT, 32'd1);
        write_reg(REG_MAXT, 32'hFFFF);
      end
      default: begin
        write_reg(REG_MSS, 32'($urandom_range(1, 4000)));
        write_reg(REG_PMW, $urandom);
        write_reg(REG_DEFT, 32'($urandom_range(1, 65535)));
        write_reg(REG_MINT, 32'($urandom_range(1, 500)));
        write_reg(REG_MAXT, 32'($urandom_range(300, 65535)));
      end
    endcase
    cfg_we <= 1'b0;
  endtask

  task automatic test_random(int n);
    int choice, idx;
    open_conn($urandom);
    for (int i = 0; i < n; i++) begin
      choice = $urandom_range(0, 99);
      if (choice < 2) open_conn($urandom);
      else if (choice < 45) send_segment(16'($urandom_range(0, 3) == 0 ? $urandom :
                                             $urandom_range(1, 1500)), 1'($urandom));
      else if (choice < 70 && tb_starts.size() > 1) begin
        idx = $urandom_range(1, tb_starts.size() - 1);
        recv_ack(tb_starts[idx]);
        for (int j = 0; j < idx; j++) void'(tb_starts.pop_front());
      end else if (choice < 80) begin
        recv_ack(tb_seq);
        if (tb_starts.size() != 0) tb_starts.delete();
      end else if (choice < 92) begin
        recv_ack(tb_starts.size() != 0 ? tb_starts[0] : tb_seq);
      end else if (choice < 97) recv_ack($urandom);
      else send_event(2'($urandom), $urandom, 16'($urandom), 16'($urandom), $urandom,
                      1'($urandom));
    end
  endtask

  initial begin
    model_reset();
    tb_now = 0;
    tb_seq = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(300);
    test_config(0);
    test_directed();
    test_random(300);
    test_config(1);
    test_random(400);
    test_config(2);
    test_random(400);
    test_config(2);
    test_random(400);
    drain();
    $display("%0d events sent, %0d results checked, %0d errors", events_sent, results_seen,
             errors);
    $display("status counts: %0d %0d %0d %0d %0d %0d %0d %0d %0d", status_hits[0],
             status_hits[1], status_hits[2], status_hits[3], status_hits[4],
             status_hits[5], status_hits[6], status_hits[7], status_hits[8]);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #10000000;
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
